// ===== src/button_debounce_press_detect_unit_macros.svh =====
// Assertion macros shared by the button debounce and press detect modules.
`ifndef BUTTON_DEBOUNCE_PRESS_DETECT_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_DETECT_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define DBP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("dbp assertion failed");

// Next-cycle implication, checked outside reset.
`define DBP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("dbp assertion failed");

`else

`define DBP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define DBP_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== src/dbp_pkg.sv =====
// Package with configuration types and constants for the button debouncer.
package dbp_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS   = 1'b0,
    REG_LONG_PRESS_TICKS = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic deb;
    logic press;
    logic lng;
  } lane_res_t;

endpackage

// ===== src/dbp_cfg.sv =====
// Configuration register file for the button debouncer.
module dbp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dbp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [dbp_pkg::CFG_W-1:0]     cfg_wdata,
  output dbp_pkg::cfg_t                 cfg
);
  import dbp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_DEBOUNCE_TICKS:   cfg_nxt.debounce_ticks   = cfg_wdata;
        REG_LONG_PRESS_TICKS: cfg_nxt.long_press_ticks = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RESET;
      cfg_r.long_press_ticks <= LONG_PRESS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/dbp_lane.sv =====
// Per-button debounce state and press / long-press detection.
`include "button_debounce_press_detect_unit_macros.svh"

module dbp_lane #(
  parameter int TICK_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 raw,
  input  logic                 take_press,
  input  logic                 take_long,
  input  dbp_pkg::cfg_t        cfg,
  output dbp_pkg::lane_res_t   res
);
  import dbp_pkg::*;

  localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

  logic                 last_raw_r, last_raw_nxt;
  logic [TICK_BITS-1:0] cnt_r, cnt_nxt;
  logic                 deb_r, deb_nxt;
  logic                 pt_r, pt_nxt;
  logic                 lt_r, lt_nxt;

  logic                 changed;
  logic [TICK_BITS-1:0] cnt_inc;
  logic                 follow;
  logic                 clr;
  logic                 pt_mid, lt_mid;
  logic                 pev, lev;

  always_comb begin
    changed = (raw != last_raw_r);
    cnt_inc = (cnt_r == '1) ? cnt_r : cnt_r + TICK_BITS'(1);
    cnt_nxt = changed ? '0 : cnt_inc;
    follow  = !changed &&
              (CMP_W'(cnt_inc) >= CMP_W'(cfg.debounce_ticks));
    // Flags clear when the level is confirmed while the old debounced level is low.
    clr     = follow && !deb_r;
    deb_nxt = follow ? raw : deb_r;
    pt_mid  = clr ? 1'b0 : pt_r;
    lt_mid  = clr ? 1'b0 : lt_r;
    pev     = take_press && deb_nxt && !pt_mid;
    lev     = take_long && deb_nxt && !lt_mid &&
              (CMP_W'(cnt_nxt) > CMP_W'(cfg.long_press_ticks));
    pt_nxt  = pt_mid | pev;
    lt_nxt  = lt_mid | lev;
    last_raw_nxt = raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      cnt_r      <= '0;
      deb_r      <= 1'b0;
      pt_r       <= 1'b0;
      lt_r       <= 1'b0;
    end else if (adv) begin
      last_raw_r <= last_raw_nxt;
      cnt_r      <= cnt_nxt;
      deb_r      <= deb_nxt;
      pt_r       <= pt_nxt;
      lt_r       <= lt_nxt;
    end
  end

  assign res.deb   = deb_nxt;
  assign res.press = pev;
  assign res.lng   = lev;

  `DBP_ASSERT_NOW(a_press_needs_level, clk, rst_n, adv && pev, deb_nxt)
  `DBP_ASSERT_NXT(a_change_holds_level, clk, rst_n, adv && changed, deb_r == $past(deb_r))
  `DBP_ASSERT_NXT(a_press_marks_taken, clk, rst_n, adv && pev, pt_r)
  `DBP_ASSERT_NOW(a_long_needs_count, clk, rst_n, adv && lev, !changed && cnt_nxt != '0)

endmodule

// ===== src/button_debounce_press_detect_unit.sv =====
// Top level of the four-button debouncer with press and long-press detection.
//
// Each input item is one millisecond tick. in_tdata carries the raw button
// levels, a mask of presses taken now and a mask of long presses taken now.
// Each tick yields exactly one result item on the out_ channel: the debounced
// levels after the tick, and the press and long-press events newly reported.
// The input item is held in an input register; a single pass of per-button
// compare and saturating-increment logic then loads the result register and
// updates the button state, and the result register drives out_tvalid and
// out_tdata; one item per cycle is sustained while out_tready is high. When
// the receiver stalls, the result stays in the output register and the input
// register still takes one more item; in_tready then falls until the result
// is taken. Reset (rst_n low, synchronous) clears all button state, empties
// both registers and loads debounce_ticks = 50 and long_press_ticks = 1000.
// Registers are written through cfg_we / cfg_addr / cfg_wdata; the user must
// write them only while the block is idle, and the block itself does not
// enforce this.
`include "button_debounce_press_detect_unit_macros.svh"

module button_debounce_press_detect_unit #(
  parameter int BUTTONS   = 4,
  parameter int TICK_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: raw_levels, take_press, take_long (lowest bits first), zero pad
  input  logic [((3*BUTTONS+7)/8)*8-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: debounced_levels, press_events, long_events (lowest first), zero pad
  output logic [((3*BUTTONS+7)/8)*8-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [dbp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [dbp_pkg::CFG_W-1:0]         cfg_wdata
);
  import dbp_pkg::*;

  localparam int DATA_W = 3 * BUTTONS;
  localparam int BUS_W  = ((DATA_W + 7) / 8) * 8;

  cfg_t cfg;

  logic               s1_valid_r, s1_valid_nxt;
  logic [BUTTONS-1:0] s1_raw_r, s1_tp_r, s1_tl_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BUTTONS-1:0] out_deb_r, out_pev_r, out_lev_r;
  logic [BUTTONS-1:0] deb_nxt, pev_nxt, lev_nxt;
  logic               adv;
  logic               in_acc;

  dbp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  genvar g;
  generate
    for (g = 0; g < BUTTONS; g++) begin : g_lane
      lane_res_t res;
      dbp_lane #(.TICK_BITS(TICK_BITS)) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .raw        (s1_raw_r[g]),
        .take_press (s1_tp_r[g]),
        .take_long  (s1_tl_r[g]),
        .cfg        (cfg),
        .res        (res)
      );
      assign deb_nxt[g] = res.deb;
      assign pev_nxt[g] = res.press;
      assign lev_nxt[g] = res.lng;
    end
  endgenerate

  // The input register drains whenever the result register is free or being read.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r <= in_tdata[BUTTONS-1:0];
      s1_tp_r  <= in_tdata[2*BUTTONS-1:BUTTONS];
      s1_tl_r  <= in_tdata[3*BUTTONS-1:2*BUTTONS];
    end
    if (adv) begin
      out_deb_r <= deb_nxt;
      out_pev_r <= pev_nxt;
      out_lev_r <= lev_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = BUS_W'({out_lev_r, out_pev_r, out_deb_r});

  `DBP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !s1_valid_r, in_tready)
  `DBP_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, s1_valid_r && out_valid_r && !out_tready, !in_tready)
  `DBP_ASSERT_NXT(a_adv_fills_output, clk, rst_n, adv, out_valid_r)

endmodule
